// ===== hdl/ppp_pkg.sv =====
`timescale 1ns / 1ps
package ppp_pkg;

    localparam int LINE_DEPTH = 20;
    localparam int IDX_W      = 5;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(LINE_DEPTH - 1);
    localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(LINE_DEPTH);

    // signature bytes
    localparam logic [7:0] SIG_START = 8'h7e;
    localparam logic [7:0] SIG_ZERO  = 8'h00;
    localparam logic [7:0] SIG_TYPE  = 8'h41;
    localparam logic [7:0] SIG_EXT0  = 8'h79;
    localparam logic [7:0] SIG_EXT2  = 8'h0d;
    localparam logic [7:0] SIG_TAIL  = 8'h2e;
    localparam logic [7:0] TYPE_BITS = 8'h06;

    // mutation modes
    localparam logic [2:0] MODE_OFF      = 3'd0;
    localparam logic [2:0] MODE_MSGTYPE  = 3'd1;
    localparam logic [2:0] MODE_SECHDR   = 3'd2;
    localparam logic [2:0] MODE_REGTYPE  = 3'd3;
    localparam logic [2:0] MODE_IDLENGTH = 3'd4;
    localparam logic [2:0] MODE_TAILBCD  = 3'd5;
    localparam logic [2:0] MODE_TYPEBITS = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_BYTE = 2'd1;
    localparam logic [1:0] CFG_LEN  = 2'd2;

    typedef logic [LINE_DEPTH-1:0][7:0] t_line;
    typedef logic [LINE_DEPTH-1:0]      t_marks;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       patched;
    } t_word;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  rep_byte;
        logic [15:0] rep_len;
    } t_cfg;

    function automatic logic [IDX_W-1:0] window_length(input logic [2:0] mode);
        logic [IDX_W-1:0] w;
        case (mode)
            MODE_MSGTYPE:  w = IDX_W'(3);
            MODE_SECHDR:   w = IDX_W'(3);
            MODE_REGTYPE:  w = IDX_W'(4);
            MODE_IDLENGTH: w = IDX_W'(6);
            MODE_TAILBCD:  w = IDX_W'(20);
            MODE_TYPEBITS: w = IDX_W'(7);
            default:       w = '0;
        endcase
        return w;
    endfunction

    // signature test on the window that starts at the oldest held byte
    function automatic logic sig_match(input t_line v, input logic [2:0] mode);
        logic base;
        logic ext;
        base = (v[0] == SIG_START) && (v[1] == SIG_ZERO) && (v[2] == SIG_TYPE);
        ext  = (v[3] == SIG_EXT0) && (v[4] == SIG_ZERO) && (v[5] == SIG_EXT2);
        if (mode >= MODE_IDLENGTH) begin
            base = base && ext;
            if (mode == MODE_TAILBCD) begin
                base = base && (v[LAST_POS] == SIG_TAIL);
            end
        end
        return base;
    endfunction

endpackage

// ===== hdl/ppp_front.sv =====
`timescale 1ns / 1ps
module ppp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data,
    input  logic           i_last,
    input  logic           i_up,
    input  ppp_pkg::t_cfg  i_cfg,
    input  logic           i_q_full,
    output logic           o_stall,
    output logic           o_push,
    output ppp_pkg::t_word o_word
);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_FLUSH = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    ppp_pkg::t_line                r_line, n_line;
    ppp_pkg::t_marks               r_mark, n_mark;
    logic [ppp_pkg::IDX_W-1:0]     r_held, n_held;
    logic                          r_up, n_up;
    logic                          r_done, n_done;

    ppp_pkg::t_line                view, pv;
    ppp_pkg::t_marks               vmark, pm;
    logic                          accept, test_en, test_up, hit;
    logic [ppp_pkg::IDX_W-1:0]     test_cnt, wlen;

    assign o_stall = (r_state == ST_FLUSH) || i_q_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        view  = r_line;
        vmark = r_mark;
        if (accept) begin
            view[r_held]  = i_data;
            vmark[r_held] = 1'b0;
        end

        test_en  = (accept && !i_last && (r_held == ppp_pkg::LAST_POS))
                 || ((r_state == ST_FLUSH) && !i_q_full);
        test_up  = (r_state == ST_FLUSH) ? r_up : i_up;
        test_cnt = (r_state == ST_FLUSH) ? r_held : ppp_pkg::FULL_CNT;
        wlen     = ppp_pkg::window_length(i_cfg.mode);
        hit      = test_en && !r_done && test_up && (wlen != '0) && (wlen <= test_cnt)
                 && ppp_pkg::sig_match(view, i_cfg.mode);

        pv = view;
        pm = vmark;
        if (hit) begin
            case (i_cfg.mode)
                ppp_pkg::MODE_MSGTYPE: begin
                    pv[2] = i_cfg.rep_byte; pm[2] = 1'b1;
                end
                ppp_pkg::MODE_SECHDR: begin
                    pv[1] = i_cfg.rep_byte; pm[1] = 1'b1;
                end
                ppp_pkg::MODE_REGTYPE: begin
                    pv[3] = i_cfg.rep_byte; pm[3] = 1'b1;
                end
                ppp_pkg::MODE_IDLENGTH: begin
                    pv[4] = i_cfg.rep_len[15:8]; pm[4] = 1'b1;
                    pv[5] = i_cfg.rep_len[7:0];  pm[5] = 1'b1;
                end
                ppp_pkg::MODE_TAILBCD: begin
                    pv[ppp_pkg::LAST_POS] = i_cfg.rep_byte;
                    pm[ppp_pkg::LAST_POS] = 1'b1;
                end
                default: begin
                    pv[6] = ppp_pkg::TYPE_BITS; pm[6] = 1'b1;
                end
            endcase
        end

        o_push         = test_en;
        o_word.data    = view[0];
        o_word.last    = (r_state == ST_FLUSH) && (r_held == ppp_pkg::IDX_W'(1));
        o_word.patched = vmark[0];

        n_state = r_state;
        n_line  = r_line;
        n_mark  = r_mark;
        n_held  = r_held;
        n_up    = r_up;
        n_done  = r_done || hit;

        if (test_en) begin
            // advance the line by one byte
            for (int i = 0; i < ppp_pkg::LINE_DEPTH - 1; i++) begin
                n_line[i] = pv[i+1];
                n_mark[i] = pm[i+1];
            end
            n_line[ppp_pkg::LAST_POS] = '0;
            n_mark[ppp_pkg::LAST_POS] = 1'b0;
            if (r_state == ST_FLUSH) begin
                n_held = r_held - ppp_pkg::IDX_W'(1);
                if (r_held == ppp_pkg::IDX_W'(1)) begin
                    n_state = ST_FILL;
                end
            end
        end else if (accept) begin
            n_line = view;
            n_mark = vmark;
            n_held = r_held + ppp_pkg::IDX_W'(1);
            if (i_last) begin
                n_up    = i_up;
                n_state = ST_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_line  <= '0;
            r_mark  <= '0;
            r_held  <= '0;
            r_up    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            r_mark  <= n_mark;
            r_held  <= n_held;
            r_up    <= n_up;
            r_done  <= n_done;
        end
    end

endmodule

// ===== hdl/ppp_queue.sv =====
`timescale 1ns / 1ps
module ppp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppp_pkg::t_word i_word,
    input  logic           i_stall,
    output logic           o_full,
    output logic           o_valid,
    output ppp_pkg::t_word o_word
);

    ppp_pkg::t_word r_q [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           pop, push;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rd];
    assign pop     = o_valid && !i_stall;
    assign push    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== hdl/packet_pattern_patcher_core.sv =====
`timescale 1ns / 1ps
// Byte-stream patcher with a twenty-byte delay line.
// Input channel (i_in_valid / o_in_stall): one message byte per word with its
// end-of-message mark and uplink flag. Output channel (o_out_valid /
// i_out_stall): the delayed byte, its last mark and a patched flag.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 mode,
// 1 replacement byte, 2 replacement length; write only while idle.
// Throughput: one byte per cycle while a message lasts and the output queue
// has room. Once 19 bytes are held each new byte pushes the oldest out, and
// that word is registered in the output queue before it can be taken.
// After the last byte of a message the front sequencer drains the line into
// the output queue, one byte a cycle while the queue has room, and holds
// o_in_stall high meanwhile. Each drained byte first has the signature window
// at its position tested.
// Reset clears the line, counters, the one-shot patch flag and config to
// mode off, byte 0x5c and length 13. A stalled receiver fills the two-word
// output queue, after which the front stops and holds o_in_stall high.
module packet_pattern_patcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    input  logic        i_uplink,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_byte_was_patched,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    ppp_pkg::t_cfg  r_cfg;
    ppp_pkg::t_word push_word, out_word;
    logic           push, q_full;

    assign o_cfg_ready = 1'b1;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= ppp_pkg::MODE_OFF;
            r_cfg.rep_byte <= 8'd92;
            r_cfg.rep_len  <= 16'd13;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ppp_pkg::CFG_MODE: r_cfg.mode     <= i_cfg_data[2:0];
                ppp_pkg::CFG_BYTE: r_cfg.rep_byte <= i_cfg_data[7:0];
                ppp_pkg::CFG_LEN:  r_cfg.rep_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept, hold and test bytes, drain on end of message
    ppp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_data_byte),
        .i_last   (i_end_of_message),
        .i_up     (i_uplink),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_word   (push_word)
    );

    // back: short output queue toward the receiver
    ppp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_stall (i_out_stall),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .o_word  (out_word)
    );

    assign o_out_byte         = out_word.data;
    assign o_out_last         = out_word.last;
    assign o_byte_was_patched = out_word.patched;

endmodule

// ===== hdl/ppp_checker.sv =====
`timescale 1ns / 1ps
module ppp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_end_of_message,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic       o_byte_was_patched
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_byte) && $stable(o_out_last) && $stable(o_byte_was_patched))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_flush_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_end_of_message |=> o_in_stall)
        else $error("input not held off during end-of-message drain");

endmodule

bind packet_pattern_patcher_core ppp_checker u_ppp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_end_of_message   (i_end_of_message),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_out_byte         (o_out_byte),
    .o_out_last         (o_out_last),
    .o_byte_was_patched (o_byte_was_patched)
);
